### rtl/rrts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Types, constants and helpers for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // ready queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // slice reload value after reset
  localparam logic [15:0] TimeSliceReset = 16'd100;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_TICK     = 2'd2,
    OP_SET      = 2'd3
  } op_e;

  // control sequencer
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_e;

  // input word
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] task_id;
  } item_t;

  // result word
  typedef struct packed {
    logic [7:0] current_task;
    logic       switched;
    logic       expired;
    logic [4:0] queue_count;
    logic       overflow;
  } result_t;

  // circular pointer advance
  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    if (idx == IdxW'(QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = idx + IdxW'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/round_robin_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Run queue of ready task ids in a synchronous memory, running task id and a
// time-slice down counter.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Add, tick, set and a
// schedule on an empty queue give their result in the cycle after acceptance
// and the next word may follow at once. A schedule on a non-empty queue raises
// busy in the pop state while the head entry is read from the queue memory
// into a registered read word, and its result is registered as the pop state
// ends. Each result is shown on result_o for exactly one cycle with valid_o
// high; the receiver cannot stall it. The time slice register may be written
// at any edge the block is idle.
module round_robin_task_scheduler (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire rrts_pkg::item_t   item_i,
  output logic                   valid_o,
  output rrts_pkg::result_t      result_o,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i
);

  // queue memory
  logic [7:0] mem_q [rrts_pkg::QueueDepth];
  logic [7:0] rdata_q;
  logic                      mem_we;
  logic [rrts_pkg::IdxW-1:0] mem_waddr;
  logic [7:0]                mem_wdata;
  logic                      mem_re;

  // control and architectural state
  rrts_pkg::state_e          state_q, state_d;
  logic [rrts_pkg::IdxW-1:0] head_q, head_d;
  logic [rrts_pkg::IdxW-1:0] tail_q, tail_d;
  logic [rrts_pkg::CntW-1:0] count_q, count_d;
  logic [7:0]                running_q, running_d;
  logic [15:0]               slice_q, slice_d;
  logic [15:0]               tslice_q;
  logic                      valid_q, valid_d;
  rrts_pkg::result_t         result_q, result_d;

  logic accept;
  logic switched;
  logic overflow;

  assign accept = start && (state_q == rrts_pkg::ST_IDLE);

  // next state and result
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    running_d = running_q;
    slice_d   = slice_q;
    valid_d   = 1'b0;
    switched  = 1'b0;
    overflow  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = tail_q;
    mem_wdata = item_i.task_id;
    mem_re    = 1'b0;
    unique case (state_q)
      rrts_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (rrts_pkg::op_e'(item_i.operation))
            rrts_pkg::OP_ADD: begin
              valid_d = 1'b1;
              if (count_q >= rrts_pkg::CntW'(rrts_pkg::QueueDepth)) begin
                overflow = 1'b1;
              end else begin
                mem_we  = 1'b1;
                tail_d  = rrts_pkg::next_idx(tail_q);
                count_d = count_q + rrts_pkg::CntW'(1);
              end
            end
            rrts_pkg::OP_SCHEDULE: begin
              if (count_q != '0) begin
                mem_re  = 1'b1;
                state_d = rrts_pkg::ST_POP;
              end else begin
                valid_d = 1'b1;
              end
            end
            rrts_pkg::OP_TICK: begin
              valid_d = 1'b1;
              if (slice_q != '0) begin
                slice_d = slice_q - 16'd1;
              end
            end
            rrts_pkg::OP_SET: begin
              valid_d   = 1'b1;
              running_d = item_i.task_id;
            end
            default: ;
          endcase
        end
      end
      rrts_pkg::ST_POP: begin
        // head word is back: rotate running task to the tail
        mem_we    = 1'b1;
        mem_wdata = running_q;
        head_d    = rrts_pkg::next_idx(head_q);
        tail_d    = rrts_pkg::next_idx(tail_q);
        running_d = rdata_q;
        slice_d   = tslice_q;
        switched  = 1'b1;
        valid_d   = 1'b1;
        state_d   = rrts_pkg::ST_IDLE;
      end
      default: state_d = rrts_pkg::ST_IDLE;
    endcase
    result_d.current_task = running_d;
    result_d.switched     = switched;
    result_d.expired      = (slice_d == '0);
    result_d.queue_count  = 5'(count_d);
    result_d.overflow     = overflow;
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[head_q];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rrts_pkg::ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      running_q <= '0;
      slice_q   <= '0;
      tslice_q  <= rrts_pkg::TimeSliceReset;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      running_q <= running_d;
      slice_q   <= slice_d;
      valid_q   <= valid_d;
      if (cfg_we_i) begin
        tslice_q <= cfg_wdata_i;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign busy     = (state_q == rrts_pkg::ST_POP);
  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

### rtl/rrts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks for the round-robin task scheduler, bound to the top.
// ----------------------------------------------------------------------------
module rrts_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire rrts_pkg::item_t   item_i,
  input wire logic              valid_o,
  input wire rrts_pkg::result_t result_o
);

  // add, tick and set words answer on the next edge
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.operation != rrts_pkg::OP_SCHEDULE) |=> valid_o)
    else $error("missing result after single-cycle operation");

  // the pop wait ends on the next edge in a result
  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (valid_o && !busy))
    else $error("pop wait did not end in a result");

  // a switch always comes out of the pop wait
  a_switch_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.switched) |-> $past(busy))
    else $error("switch reported without a queue read");

  // a dropped add only happens on a full queue
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.overflow) |->
      (result_o.queue_count == 5'(rrts_pkg::QueueDepth) && !result_o.switched))
    else $error("overflow reported on a queue that is not full");

  // no result without a word behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(start && !busy) && !$past(busy)) |-> !valid_o)
    else $error("result without an accepted word");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .valid_o  (valid_o),
  .result_o (result_o)
);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin task scheduler. Directed words hit
// the corner cases: empty schedule, full queue drop, same id at head and tick
// at zero. Random phases follow, each with its own slice length (a zero slice
// among them), op mix and idle pattern. Results are checked against a model.
// ----------------------------------------------------------------------------

// model of the run queue, running task and slice counter, plus due results
class sched_scoreboard;
  logic [7:0]          ready_ids[$];
  logic [7:0]          running;
  logic [15:0]         slice_left;
  logic [15:0]         slice_len;
  rrts_pkg::result_t   due_results[$];
  int                  errors;
  int                  n_words;
  int                  n_results;
  int                  n_switches;
  int                  n_drops;
  int                  n_expired;

  function new();
    running    = '0;
    slice_left = '0;
    slice_len  = rrts_pkg::TimeSliceReset;
    errors     = 0;
    n_words    = 0;
    n_results  = 0;
    n_switches = 0;
    n_drops    = 0;
    n_expired  = 0;
  endfunction

  function void set_slice(input logic [15:0] v);
    slice_len = v;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  // apply one accepted word and queue the result it must produce
  function void note_word(input rrts_pkg::item_t w);
    rrts_pkg::result_t r;
    r = '0;
    case (rrts_pkg::op_e'(w.operation))
      rrts_pkg::OP_ADD: begin
        if (ready_ids.size() >= rrts_pkg::QueueDepth) begin
          r.overflow = 1'b1;
        end else begin
          ready_ids.push_back(w.task_id);
        end
      end
      rrts_pkg::OP_SCHEDULE: begin
        if (ready_ids.size() != 0) begin
          ready_ids.push_back(running);
          running    = ready_ids.pop_front();
          slice_left = slice_len;
          r.switched = 1'b1;
        end
      end
      rrts_pkg::OP_TICK: begin
        if (slice_left != 0) begin
          slice_left = slice_left - 16'd1;
        end
      end
      default: begin
        running = w.task_id;
      end
    endcase
    r.current_task = running;
    r.expired      = (slice_left == 0);
    r.queue_count  = 5'(ready_ids.size());
    n_words++;
    if (r.switched) n_switches++;
    if (r.overflow) n_drops++;
    if (r.expired) n_expired++;
    due_results.push_back(r);
  endfunction

  // compare one result word with the oldest due result
  function void check_result(input rrts_pkg::result_t got);
    rrts_pkg::result_t e;
    n_results++;
    if (due_results.size() == 0) begin
      $error("result with nothing due: %h", got);
      errors++;
      return;
    end
    e = due_results.pop_front();
    if (got.current_task !== e.current_task) begin
      $error("current_task: expected %0d, got %0d", e.current_task, got.current_task);
      errors++;
    end
    if (got.switched !== e.switched) begin
      $error("switched: expected %0d, got %0d", e.switched, got.switched);
      errors++;
    end
    if (got.expired !== e.expired) begin
      $error("expired: expected %0d, got %0d", e.expired, got.expired);
      errors++;
    end
    if (got.queue_count !== e.queue_count) begin
      $error("queue_count: expected %0d, got %0d", e.queue_count, got.queue_count);
      errors++;
    end
    if (got.overflow !== e.overflow) begin
      $error("overflow: expected %0d, got %0d", e.overflow, got.overflow);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int CycleLimit = 200000;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  rrts_pkg::item_t   item_i;
  logic              valid_o;
  rrts_pkg::result_t result_o;
  logic              cfg_we_i;
  logic [15:0]       cfg_wdata_i;

  sched_scoreboard sb = new();
  bit              idle_en;
  int              cycles;
  int              n_settings;

  round_robin_task_scheduler DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .valid_o    (valid_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("round_robin_task_scheduler test failed");
      $finish;
    end
  end

  // note accepted words and check result words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_word(item_i);
      if (valid_o) sb.check_result(result_o);
    end
  end

  // send one word, with a random gap before it when idling is on
  task automatic send_word(input rrts_pkg::op_e op, input logic [7:0] id);
    if (idle_en && $urandom_range(99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= '{operation: op, task_id: id};
    do @(posedge clk_i); while (busy);
  endtask

  // let all results come back, then load a new slice length
  task automatic write_slice(input logic [15:0] v);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_slice(v);
    n_settings++;
  endtask

  // weighted op pick, set current task takes the remainder
  function automatic rrts_pkg::op_e pick_op(input int add_w, input int sched_w,
                                            input int tick_w);
    int r;
    r = $urandom_range(99);
    if (r < add_w) return rrts_pkg::OP_ADD;
    if (r < add_w + sched_w) return rrts_pkg::OP_SCHEDULE;
    if (r < add_w + sched_w + tick_w) return rrts_pkg::OP_TICK;
    return rrts_pkg::OP_SET;
  endfunction

  // one random phase under a given slice length and op mix
  task automatic run_phase(input logic [15:0] slice, input int count, input int add_w,
                           input int sched_w, input int tick_w, input bit idle_on);
    write_slice(slice);
    idle_en = idle_on;
    repeat (count) send_word(pick_op(add_w, sched_w, tick_w), 8'($urandom_range(255)));
  endtask

  initial begin
    n_settings  = 0;
    idle_en     = 1'b1;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset slice length: tick at zero, empty schedule, first switch
    send_word(rrts_pkg::OP_TICK, 8'h00);
    send_word(rrts_pkg::OP_SCHEDULE, 8'h00);
    send_word(rrts_pkg::OP_SET, 8'hA5);
    send_word(rrts_pkg::OP_ADD, 8'h00);
    send_word(rrts_pkg::OP_SCHEDULE, 8'hFF);

    // short slice: count down to expiry, tick at zero, same id at head
    write_slice(16'd2);
    send_word(rrts_pkg::OP_SCHEDULE, 8'h00);
    send_word(rrts_pkg::OP_TICK, 8'h00);
    send_word(rrts_pkg::OP_TICK, 8'h00);
    send_word(rrts_pkg::OP_TICK, 8'h00);
    send_word(rrts_pkg::OP_SET, 8'h00);
    send_word(rrts_pkg::OP_SCHEDULE, 8'h00);

    // fill the queue, drop on full, rotate a full queue
    send_word(rrts_pkg::OP_ADD, 8'hFF);
    for (int i = 1; i < 15; i++) send_word(rrts_pkg::OP_ADD, 8'(i * 17));
    send_word(rrts_pkg::OP_ADD, 8'h5A);
    send_word(rrts_pkg::OP_SCHEDULE, 8'h00);
    send_word(rrts_pkg::OP_ADD, 8'hC3);

    // random phases, extremes of the slice among them
    run_phase(16'd1, 100, 45, 30, 20, 1'b1);
    run_phase(16'hFFFF, 90, 60, 15, 15, 1'b1);
    run_phase(16'd0, 60, 30, 35, 20, 1'b1);
    run_phase(16'd3, 120, 35, 30, 30, 1'b0);
    run_phase(16'($urandom_range(1, 65535)), 80, 25, 45, 20, 1'b1);
    run_phase(rrts_pkg::TimeSliceReset, 100, 40, 30, 20, 1'b1);

    // drain and finish
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("covered %0d words under %0d slice settings: %0d switches, %0d drops",
             sb.n_words, n_settings, sb.n_switches, sb.n_drops);
    $display("%0d results checked, %0d showed an expired slice, %0d errors",
             sb.n_results, sb.n_expired, sb.errors);
    if (sb.errors == 0) begin
      $display("round_robin_task_scheduler test passed");
    end else begin
      $display("round_robin_task_scheduler test failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/rrts_pkg.sv
rtl/round_robin_task_scheduler.sv
rtl/rrts_checker.sv
tb/tb.sv
